>>> rtl/lsni_pkg.sv
// ----------------------------------------------------------------------------
// lsni_pkg
// Shared widths, register indexes, multiplier op codes and result type for
// the lattice site neighbor indexer.
// ----------------------------------------------------------------------------
package lsni_pkg;

	localparam int EXT_W = 7;
	localparam int CRD_W = 6;
	localparam int IDX_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam int MAX_EXTENT_DEF = 64;

	localparam logic [EXT_W-1:0] EXTENT_RST = 7'd8;
	localparam logic [IDX_W-1:0] HALF_VOL_RST = 24'd2048;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXTENT_T = 3'd0,
		REG_EXTENT_X = 3'd1,
		REG_EXTENT_Y = 3'd2,
		REG_EXTENT_Z = 3'd3,
		REG_HALF_VOL = 3'd4
	} cfg_reg_t;

	// operand selection of the shared multiplier
	typedef enum logic [3:0] {
		OP_NONE,
		OP_SX,
		OP_ST,
		OP_WY,
		OP_WX,
		OP_WT,
		OP_T,
		OP_X,
		OP_Y
	} mul_op_t;

	typedef struct packed {
		mul_op_t mul_op;
		logic    capture;
		logic    finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic [IDX_W-1:0] site_index;
		logic             is_even;
		logic [IDX_W-1:0] eo_index;
		logic [IDX_W-1:0] up_t;
		logic [IDX_W-1:0] down_t;
		logic [IDX_W-1:0] up_x;
		logic [IDX_W-1:0] down_x;
		logic [IDX_W-1:0] up_y;
		logic [IDX_W-1:0] down_y;
		logic [IDX_W-1:0] up_z;
		logic [IDX_W-1:0] down_z;
		logic             range_error;
	} result_t;

	// saturate an extent to the largest supported one
	function automatic logic [EXT_W-1:0] clamp_ext(logic [EXT_W-1:0] e, int max_ext);
		logic [EXT_W-1:0] r;
		if (int'(e) > max_ext) begin
			r = EXT_W'(max_ext);
		end else begin
			r = e;
		end
		return r;
	endfunction

endpackage

>>> rtl/lsni_ctrl.sv
// ----------------------------------------------------------------------------
// lsni_ctrl
// Sequencer: recomputes strides after reset or a register write, then walks
// each accepted word through three multiplies and a finish step.
// ----------------------------------------------------------------------------
module lsni_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cfg_we,
	input  lsni_pkg::dp_status_t  status,
	output lsni_pkg::dp_cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SX,
		S_ST,
		S_WY,
		S_WX,
		S_WT,
		S_MT,
		S_MX,
		S_MY,
		S_FIN
	} state_t;

	state_t state_q;
	logic   dirty_q;
	logic   accept;

	assign in_ready = !cfg_we && !dirty_q &&
		((state_q == S_IDLE) || ((state_q == S_FIN) && status.out_free));
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd = '{mul_op: lsni_pkg::OP_NONE, capture: accept, finish: 1'b0};
		unique case (state_q)
			S_SX: cmd.mul_op = lsni_pkg::OP_SX;
			S_ST: cmd.mul_op = lsni_pkg::OP_ST;
			S_WY: cmd.mul_op = lsni_pkg::OP_WY;
			S_WX: cmd.mul_op = lsni_pkg::OP_WX;
			S_WT: cmd.mul_op = lsni_pkg::OP_WT;
			S_MT: cmd.mul_op = lsni_pkg::OP_T;
			S_MX: cmd.mul_op = lsni_pkg::OP_X;
			S_MY: cmd.mul_op = lsni_pkg::OP_Y;
			S_FIN: cmd.finish = status.out_free;
			default: cmd.mul_op = lsni_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dirty_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end else if ((state_q == S_IDLE) && dirty_q) begin
				dirty_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (dirty_q) begin
						state_q <= S_SX;
					end else if (accept) begin
						state_q <= S_MT;
					end
				end
				S_SX: state_q <= S_ST;
				S_ST: state_q <= S_WY;
				S_WY: state_q <= S_WX;
				S_WX: state_q <= S_WT;
				S_WT: state_q <= S_IDLE;
				S_MT: state_q <= S_MX;
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_FIN;
				S_FIN: begin
					if (accept) begin
						state_q <= S_MT;
					end else if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_stale: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !dirty_q)
		else $error("word accepted with stale strides");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MT))
		else $error("accepted word did not start the multiply sequence");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> status.out_free)
		else $error("finish issued into a full output register");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (dirty_q && !in_ready))
		else $error("register write did not force a stride update");

endmodule

>>> rtl/lsni_dp.sv
// ----------------------------------------------------------------------------
// lsni_dp
// Datapath: register file, shared 7x24 multiplier, stride and accumulator
// registers, parity counters and the output register.
// ----------------------------------------------------------------------------
module lsni_dp #(
	parameter int MAX_EXTENT = lsni_pkg::MAX_EXTENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lsni_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsni_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_t,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_x,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_y,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_z,
	input  logic                               restart,
	input  lsni_pkg::dp_cmd_t                  cmd,
	output lsni_pkg::dp_status_t               status,
	output lsni_pkg::result_t                  res,
	output logic                               out_valid,
	input  logic                               out_ready
);

	localparam int EW = lsni_pkg::EXT_W;
	localparam int CW = lsni_pkg::CRD_W;
	localparam int IW = lsni_pkg::IDX_W;

	logic [EW-1:0] ext_t_q, ext_x_q, ext_y_q, ext_z_q;
	logic [IW-1:0] half_vol_q;
	logic [EW-1:0] et, ex, ey, ez;

	logic [IW-1:0] sx_q, st_q, wt_q, wx_q, wy_q;
	logic [CW-1:0] crd_t_q, crd_x_q, crd_y_q, crd_z_q;
	logic          restart_q;
	logic [IW-1:0] prod_q, acc_q, pt_q, px_q;
	logic [IW-1:0] even_q, odd_q;

	lsni_pkg::result_t res_q;
	logic              out_valid_q;

	logic [EW-1:0]    mul_a;
	logic [IW-1:0]    mul_b;
	logic [EW+IW-1:0] mul_full;
	logic [IW-1:0]    mul_out;

	lsni_pkg::result_t nxt;
	logic [IW-1:0]     base;
	logic [IW-1:0]     ev_cnt, od_cnt;
	logic [EW-1:0]     t_inc, x_inc, y_inc, z_inc;
	logic              err;

	assign et = lsni_pkg::clamp_ext(ext_t_q, MAX_EXTENT);
	assign ex = lsni_pkg::clamp_ext(ext_x_q, MAX_EXTENT);
	assign ey = lsni_pkg::clamp_ext(ext_y_q, MAX_EXTENT);
	assign ez = lsni_pkg::clamp_ext(ext_z_q, MAX_EXTENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_t_q    <= lsni_pkg::EXTENT_RST;
			ext_x_q    <= lsni_pkg::EXTENT_RST;
			ext_y_q    <= lsni_pkg::EXTENT_RST;
			ext_z_q    <= lsni_pkg::EXTENT_RST;
			half_vol_q <= lsni_pkg::HALF_VOL_RST;
		end else if (cfg_we) begin
			unique case (lsni_pkg::cfg_reg_t'(cfg_index))
				lsni_pkg::REG_EXTENT_T: ext_t_q <= cfg_data[EW-1:0];
				lsni_pkg::REG_EXTENT_X: ext_x_q <= cfg_data[EW-1:0];
				lsni_pkg::REG_EXTENT_Y: ext_y_q <= cfg_data[EW-1:0];
				lsni_pkg::REG_EXTENT_Z: ext_z_q <= cfg_data[EW-1:0];
				lsni_pkg::REG_HALF_VOL: half_vol_q <= cfg_data[IW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_op)
			lsni_pkg::OP_SX: begin
				mul_a = ey;
				mul_b = IW'(ez);
			end
			lsni_pkg::OP_ST: begin
				mul_a = ex;
				mul_b = sx_q;
			end
			lsni_pkg::OP_WY: begin
				mul_a = ey - EW'(1);
				mul_b = IW'(ez);
			end
			lsni_pkg::OP_WX: begin
				mul_a = ex - EW'(1);
				mul_b = sx_q;
			end
			lsni_pkg::OP_WT: begin
				mul_a = et - EW'(1);
				mul_b = st_q;
			end
			lsni_pkg::OP_T: begin
				mul_a = EW'(crd_t_q);
				mul_b = st_q;
			end
			lsni_pkg::OP_X: begin
				mul_a = EW'(crd_x_q);
				mul_b = sx_q;
			end
			lsni_pkg::OP_Y: begin
				mul_a = EW'(crd_y_q);
				mul_b = IW'(ez);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_full = (EW+IW)'(mul_a) * (EW+IW)'(mul_b);
		mul_out  = mul_full[IW-1:0];
	end

	// strides and wrap offsets, plus the multiply-accumulate of one site
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			crd_t_q   <= coord_t;
			crd_x_q   <= coord_x;
			crd_y_q   <= coord_y;
			crd_z_q   <= coord_z;
			restart_q <= restart;
		end
		unique case (cmd.mul_op)
			lsni_pkg::OP_SX: sx_q <= mul_out;
			lsni_pkg::OP_ST: st_q <= mul_out;
			lsni_pkg::OP_WY: wy_q <= mul_out;
			lsni_pkg::OP_WX: wx_q <= mul_out;
			lsni_pkg::OP_WT: wt_q <= mul_out;
			lsni_pkg::OP_T: prod_q <= mul_out;
			lsni_pkg::OP_X: begin
				acc_q  <= IW'(crd_z_q) + prod_q;
				pt_q   <= prod_q;
				prod_q <= mul_out;
			end
			lsni_pkg::OP_Y: begin
				acc_q  <= acc_q + prod_q;
				px_q   <= prod_q;
				prod_q <= mul_out;
			end
			default: ;
		endcase
	end

	always_comb begin
		base   = acc_q + prod_q;
		ev_cnt = restart_q ? '0 : even_q;
		od_cnt = restart_q ? '0 : odd_q;
		t_inc  = EW'(crd_t_q) + EW'(1);
		x_inc  = EW'(crd_x_q) + EW'(1);
		y_inc  = EW'(crd_y_q) + EW'(1);
		z_inc  = EW'(crd_z_q) + EW'(1);
		err    = (EW'(crd_t_q) >= et) || (EW'(crd_x_q) >= ex) ||
			(EW'(crd_y_q) >= ey) || (EW'(crd_z_q) >= ez);

		nxt = '0;
		if (err) begin
			nxt.range_error = 1'b1;
		end else begin
			nxt.site_index = base;
			nxt.is_even    = ~(crd_t_q[0] ^ crd_x_q[0] ^ crd_y_q[0] ^ crd_z_q[0]);
			nxt.eo_index   = nxt.is_even ? ev_cnt : half_vol_q + od_cnt;
			// wrap up: drop this coordinate's term; wrap down: add (extent-1)*stride
			nxt.up_t   = (t_inc >= et) ? base - pt_q : base + st_q;
			nxt.down_t = (crd_t_q == '0) ? base + wt_q : base - st_q;
			nxt.up_x   = (x_inc >= ex) ? base - px_q : base + sx_q;
			nxt.down_x = (crd_x_q == '0) ? base + wx_q : base - sx_q;
			nxt.up_y   = (y_inc >= ey) ? base - prod_q : base + IW'(ez);
			nxt.down_y = (crd_y_q == '0) ? base + wy_q : base - IW'(ez);
			nxt.up_z   = (z_inc >= ez) ? base - IW'(crd_z_q) : base + IW'(1);
			nxt.down_z = (crd_z_q == '0) ? base + IW'(ez - EW'(1)) : base - IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_q      <= '0;
			odd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (err) begin
					even_q <= ev_cnt;
					odd_q  <= od_cnt;
				end else if (nxt.is_even) begin
					even_q <= ev_cnt + IW'(1);
					odd_q  <= od_cnt;
				end else begin
					even_q <= ev_cnt;
					odd_q  <= od_cnt + IW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= nxt;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign res             = res_q;
	assign out_valid       = out_valid_q;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(res_q)))
		else $error("stalled result word changed");

	a_counters_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.finish) |-> ($stable(even_q) && $stable(odd_q)))
		else $error("parity counters moved without a finished site");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.range_error) |-> (res_q.site_index == '0 && !res_q.is_even))
		else $error("range error word carries data");

endmodule

>>> rtl/lattice_site_neighbor_indexer.sv
// An accepted word runs through the t, x and y multiply states, then a finish
// step that registers the result once the output is free; a new word can be
// taken in that step. One shared 7x24 multiplier forms t*St, x*Sx, y*Sy in
// turn. Reset and every register write start a stride update of Sx, St and the
// y, x, t wrap offsets on that multiplier, with in_ready low until it ends.
// Reset loads the register defaults and clears the even and odd counters.
// ----------------------------------------------------------------------------
// lattice_site_neighbor_indexer
// Lexicographic, even-odd and periodic neighbor indices of one 4D lattice site.
// ----------------------------------------------------------------------------
module lattice_site_neighbor_indexer #(
	parameter int MAX_EXTENT = lsni_pkg::MAX_EXTENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lsni_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsni_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_t,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_x,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_y,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_z,
	input  logic                               restart,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lsni_pkg::IDX_W-1:0]         site_index,
	output logic                               is_even,
	output logic [lsni_pkg::IDX_W-1:0]         eo_index,
	output logic [lsni_pkg::IDX_W-1:0]         up_t,
	output logic [lsni_pkg::IDX_W-1:0]         down_t,
	output logic [lsni_pkg::IDX_W-1:0]         up_x,
	output logic [lsni_pkg::IDX_W-1:0]         down_x,
	output logic [lsni_pkg::IDX_W-1:0]         up_y,
	output logic [lsni_pkg::IDX_W-1:0]         down_y,
	output logic [lsni_pkg::IDX_W-1:0]         up_z,
	output logic [lsni_pkg::IDX_W-1:0]         down_z,
	output logic                               range_error
);

	lsni_pkg::dp_cmd_t    cmd;
	lsni_pkg::dp_status_t status;
	lsni_pkg::result_t    res;

	lsni_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cfg_we   (cfg_we),
		.status   (status),
		.cmd      (cmd)
	);

	lsni_dp #(
		.MAX_EXTENT (MAX_EXTENT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coord_t   (coord_t),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.coord_z   (coord_z),
		.restart   (restart),
		.cmd       (cmd),
		.status    (status),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	assign site_index  = res.site_index;
	assign is_even     = res.is_even;
	assign eo_index    = res.eo_index;
	assign up_t        = res.up_t;
	assign down_t      = res.down_t;
	assign up_x        = res.up_x;
	assign down_x      = res.down_x;
	assign up_y        = res.up_y;
	assign down_y      = res.down_y;
	assign up_z        = res.up_z;
	assign down_z      = res.down_z;
	assign range_error = res.range_error;

endmodule

>>> tb/lsni_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsni_checker
// Scoreboard for the lattice site neighbor indexer. Follows the register
// writes, predicts the result word of every site word taken in, and compares
// each result word field by field with the oldest prediction in line.
// ----------------------------------------------------------------------------
module lsni_checker #(
	parameter int MAX_EXTENT = lsni_pkg::MAX_EXTENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lsni_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsni_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_t,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_x,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_y,
	input  logic [lsni_pkg::CRD_W-1:0]         coord_z,
	input  logic                               restart,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [lsni_pkg::IDX_W-1:0]         site_index,
	input  logic                               is_even,
	input  logic [lsni_pkg::IDX_W-1:0]         eo_index,
	input  logic [lsni_pkg::IDX_W-1:0]         up_t,
	input  logic [lsni_pkg::IDX_W-1:0]         down_t,
	input  logic [lsni_pkg::IDX_W-1:0]         up_x,
	input  logic [lsni_pkg::IDX_W-1:0]         down_x,
	input  logic [lsni_pkg::IDX_W-1:0]         up_y,
	input  logic [lsni_pkg::IDX_W-1:0]         down_y,
	input  logic [lsni_pkg::IDX_W-1:0]         up_z,
	input  logic [lsni_pkg::IDX_W-1:0]         down_z,
	input  logic                               range_error,
	output int                                 fail_count,
	output int                                 pending_words
);

	import lsni_pkg::*;

	logic [EXT_W-1:0] extent_reg [4];
	logic [IDX_W-1:0] half_vol_reg;
	logic [IDX_W-1:0] even_seen;
	logic [IDX_W-1:0] odd_seen;
	result_t          expected_sites [$];
	result_t          want;

	initial begin
		fail_count = 0;
		pending_words = 0;
	end

	function automatic int eff_extent(cfg_reg_t r);
		int e;
		e = int'(extent_reg[r]);
		return (e > MAX_EXTENT) ? MAX_EXTENT : e;
	endfunction

	function automatic logic [IDX_W-1:0] lin_index(int t, int x, int y, int z);
		longint unsigned v;
		v = longint'(t) * eff_extent(REG_EXTENT_X) + x;
		v = v * eff_extent(REG_EXTENT_Y) + y;
		v = v * eff_extent(REG_EXTENT_Z) + z;
		return v[IDX_W-1:0];
	endfunction

	function automatic int step_up(int c, int e);
		return (c + 1 >= e) ? 0 : c + 1;
	endfunction

	function automatic int step_down(int c, int e);
		return (c == 0) ? e - 1 : c - 1;
	endfunction

	// index word of one site; clears the parity counters on restart and advances one for an in-range site
	function automatic result_t predict_site(int t, int x, int y, int z, logic clr);
		result_t r;
		int et, ex, ey, ez, s;
		et = eff_extent(REG_EXTENT_T);
		ex = eff_extent(REG_EXTENT_X);
		ey = eff_extent(REG_EXTENT_Y);
		ez = eff_extent(REG_EXTENT_Z);
		r = '0;
		if (clr) begin
			even_seen = '0;
			odd_seen = '0;
		end
		if (t >= et || x >= ex || y >= ey || z >= ez) begin
			r.range_error = 1'b1;
		end else begin
			s = t + x + y + z;
			r.site_index = lin_index(t, x, y, z);
			r.is_even = ~s[0];
			if (r.is_even) begin
				r.eo_index = even_seen;
				even_seen = even_seen + IDX_W'(1);
			end else begin
				r.eo_index = half_vol_reg + odd_seen;
				odd_seen = odd_seen + IDX_W'(1);
			end
			r.up_t   = lin_index(step_up(t, et), x, y, z);
			r.down_t = lin_index(step_down(t, et), x, y, z);
			r.up_x   = lin_index(t, step_up(x, ex), y, z);
			r.down_x = lin_index(t, step_down(x, ex), y, z);
			r.up_y   = lin_index(t, x, step_up(y, ey), z);
			r.down_y = lin_index(t, x, step_down(y, ey), z);
			r.up_z   = lin_index(t, x, y, step_up(z, ez));
			r.down_z = lin_index(t, x, y, step_down(z, ez));
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [IDX_W-1:0] exp_v, logic [IDX_W-1:0] got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_reg[REG_EXTENT_T] = EXTENT_RST;
			extent_reg[REG_EXTENT_X] = EXTENT_RST;
			extent_reg[REG_EXTENT_Y] = EXTENT_RST;
			extent_reg[REG_EXTENT_Z] = EXTENT_RST;
			half_vol_reg = HALF_VOL_RST;
			even_seen = '0;
			odd_seen = '0;
			expected_sites.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sites.size() == 0) begin
					fail_count++;
					$error("result word with no site word pending");
				end else begin
					want = expected_sites.pop_front();
					check_field("site_index", want.site_index, site_index);
					check_field("is_even", IDX_W'(want.is_even), IDX_W'(is_even));
					check_field("eo_index", want.eo_index, eo_index);
					check_field("up_t", want.up_t, up_t);
					check_field("down_t", want.down_t, down_t);
					check_field("up_x", want.up_x, up_x);
					check_field("down_x", want.down_x, down_x);
					check_field("up_y", want.up_y, up_y);
					check_field("down_y", want.down_y, down_y);
					check_field("up_z", want.up_z, up_z);
					check_field("down_z", want.down_z, down_z);
					check_field("range_error", IDX_W'(want.range_error),
						IDX_W'(range_error));
				end
			end
			if (in_valid && in_ready)
				expected_sites.push_back(predict_site(int'(coord_t), int'(coord_x),
					int'(coord_y), int'(coord_z), restart));
			if (cfg_we) begin
				case (cfg_index)
					REG_EXTENT_T, REG_EXTENT_X, REG_EXTENT_Y, REG_EXTENT_Z: begin
						extent_reg[cfg_index] = cfg_data[EXT_W-1:0];
					end
					REG_HALF_VOL: begin
						half_vol_reg = cfg_data[IDX_W-1:0];
					end
					default: begin
						// drop writes outside the register map
					end
				endcase
			end
		end
		pending_words = expected_sites.size();
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the lattice site neighbor indexer with a directed set of corner sites
// under the reset extents, then with lattice sweeps and stray sites over many
// extent and offset settings, under random and long output stalls. The
// checker beside the block scores every result word.
// ----------------------------------------------------------------------------
module testbench;

	import lsni_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int LIMIT_CYCLES    = 400000;
	localparam int NUM_PHASES      = 12;
	localparam int SITES_PER_PHASE = 132;
	localparam int LONG_HOLD       = 150;
	localparam int DRAIN_CYCLES    = 10;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [CRD_W-1:0]      coord_t = '0;
	logic [CRD_W-1:0]      coord_x = '0;
	logic [CRD_W-1:0]      coord_y = '0;
	logic [CRD_W-1:0]      coord_z = '0;
	logic                  restart = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [IDX_W-1:0]      site_index;
	logic                  is_even;
	logic [IDX_W-1:0]      eo_index;
	logic [IDX_W-1:0]      up_t;
	logic [IDX_W-1:0]      down_t;
	logic [IDX_W-1:0]      up_x;
	logic [IDX_W-1:0]      down_x;
	logic [IDX_W-1:0]      up_y;
	logic [IDX_W-1:0]      down_y;
	logic [IDX_W-1:0]      up_z;
	logic [IDX_W-1:0]      down_z;
	logic                  range_error;

	int fail_count;
	int pending_words;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int ext_set [4];
	int eff_now [4] = '{8, 8, 8, 8};
	int cur [4];

	lattice_site_neighbor_indexer dut (.*);

	lsni_checker site_check (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver: random stalls, or a long hold-off when asked for one
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic offer_site(int t, int x, int y, int z, bit clr);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		coord_t <= CRD_W'(t);
		coord_x <= CRD_W'(x);
		coord_y <= CRD_W'(y);
		coord_z <= CRD_W'(z);
		restart <= clr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, int v);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'(v);
		// junk above the extent field must be dropped
		if (r != REG_HALF_VOL)
			d[CFG_DATA_W-1:EXT_W] = (CFG_DATA_W - EXT_W)'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(negedge clk);
	endtask

	// once the block has drained, write an index outside the map, then ext_set and the odd offset
	task automatic load_config(int half);
		in_valid <= 1'b0;
		wait (pending_words == 0);
		repeat (6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'($urandom_range(int'(REG_HALF_VOL) + 1, (1 << CFG_IDX_W) - 1));
		cfg_data <= CFG_DATA_W'($urandom);
		@(negedge clk);
		write_reg(REG_EXTENT_T, ext_set[0]);
		write_reg(REG_EXTENT_X, ext_set[1]);
		write_reg(REG_EXTENT_Y, ext_set[2]);
		write_reg(REG_EXTENT_Z, ext_set[3]);
		write_reg(REG_HALF_VOL, half);
		cfg_we <= 1'b0;
		for (int d = 0; d < 4; d++)
			eff_now[d] = (ext_set[d] > MAX_EXTENT_DEF) ? MAX_EXTENT_DEF : ext_set[d];
	endtask

	// step to the next site in sweep order, z fastest
	task automatic advance_sweep();
		for (int d = 3; d >= 0; d--) begin
			if (cur[d] + 1 < eff_now[d]) begin
				cur[d]++;
				return;
			end
			cur[d] = 0;
		end
	endtask

	initial begin
		int n, len, half, vol;
		bit clr;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// corner sites under the reset extents
		send_idle = 35;
		recv_idle = 45;
		offer_site(0, 0, 0, 0, 1'b1);
		offer_site(7, 7, 7, 7, 1'b0);
		offer_site(0, 0, 0, 1, 1'b0);
		offer_site(1, 0, 0, 0, 1'b0);
		offer_site(0, 7, 0, 7, 1'b0);
		offer_site(7, 0, 7, 0, 1'b0);
		offer_site(3, 4, 5, 6, 1'b0);
		offer_site(0, 1, 0, 0, 1'b0);
		offer_site(8, 0, 0, 0, 1'b0);
		offer_site(0, 8, 0, 0, 1'b0);
		offer_site(0, 0, 8, 0, 1'b0);
		offer_site(0, 0, 0, 8, 1'b0);
		offer_site(63, 63, 63, 63, 1'b0);
		// restart still clears on an out-of-range site
		offer_site(63, 0, 0, 0, 1'b1);
		offer_site(0, 0, 0, 1, 1'b0);
		offer_site(0, 0, 0, 2, 1'b0);
		offer_site(0, 7, 7, 0, 1'b1);
		offer_site(5, 2, 7, 1, 1'b0);
		offer_site(4, 7, 0, 0, 1'b0);
		offer_site(32, 16, 4, 2, 1'b0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p * 3 / NUM_PHASES)
				0: begin
					send_idle = 35;
					recv_idle = 45;
				end
				1: begin
					send_idle = 45;
					recv_idle = 35;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int d = 0; d < 4; d++) begin
				case (p)
					0: ext_set[d] = 1;
					1: ext_set[d] = MAX_EXTENT_DEF;
					2: ext_set[d] = $urandom_range(MAX_EXTENT_DEF + 1, (1 << EXT_W) - 1);
					default: ext_set[d] = ($urandom_range(7) == 0) ?
						$urandom_range(MAX_EXTENT_DEF - 2, (1 << EXT_W) - 1) :
						$urandom_range(1, 6);
				endcase
			end
			if (p == 3)
				ext_set[$urandom_range(3)] = 0;
			vol = 1;
			for (int d = 0; d < 4; d++)
				vol *= (ext_set[d] > MAX_EXTENT_DEF) ? MAX_EXTENT_DEF : ext_set[d];
			case (p)
				0: half = 0;
				1: half = 1 << (IDX_W - 1);
				2: half = (1 << IDX_W) - 1;
				default: half = $urandom_range(1) ? int'($urandom & ((1 << IDX_W) - 1)) : vol / 2;
			endcase
			load_config(half);
			if (p == NUM_PHASES - 2)
				hold_request = 1'b1;

			n = 0;
			while (n < SITES_PER_PHASE) begin
				if ($urandom_range(99) < 75) begin
					len = $urandom_range(1, 40);
					if ($urandom_range(3) != 0) begin
						cur = '{0, 0, 0, 0};
						clr = 1'b1;
					end else begin
						for (int d = 0; d < 4; d++)
							cur[d] = (eff_now[d] > 0) ? $urandom_range(eff_now[d] - 1) : 0;
						clr = $urandom_range(1);
					end
					for (int k = 0; k < len && n < SITES_PER_PHASE; k++) begin
						offer_site(cur[0], cur[1], cur[2], cur[3], clr);
						clr = 1'b0;
						advance_sweep();
						n++;
					end
				end else begin
					// stray site, often outside the lattice
					for (int d = 0; d < 4; d++)
						cur[d] = ($urandom_range(1) || eff_now[d] == 0) ?
							$urandom_range((1 << CRD_W) - 1) : $urandom_range(eff_now[d] - 1);
					offer_site(cur[0], cur[1], cur[2], cur[3], $urandom_range(7) == 0);
					n++;
				end
			end
		end

		in_valid <= 1'b0;
		wait (pending_words == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("PASS lattice_site_neighbor_indexer");
		end else begin
			$display("FAIL lattice_site_neighbor_indexer");
		end
		$finish;
	end

	initial begin
		#(longint'(LIMIT_CYCLES) * CLK_PERIOD);
		$display("FAIL lattice_site_neighbor_indexer");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lsni_pkg.sv
rtl/lsni_ctrl.sv
rtl/lsni_dp.sv
rtl/lattice_site_neighbor_indexer.sv
tb/lsni_checker.sv
tb/testbench.sv
